// ===== sv/clock_frame_replacement_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the clock frame replacement unit
// Clocked implication checks, same cycle and next cycle, with reset disable.
// ----------------------------------------------------------------------------
`ifndef CLOCK_FRAME_REPLACEMENT_UNIT_MACROS_SVH
`define CLOCK_FRAME_REPLACEMENT_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CFR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cfr check failed");

// antecedent implies consequent in the next cycle
`define CFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cfr check failed");

`endif

// ===== sv/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the clock frame replacement unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfr_pkg;

    localparam int CFR_NUM_FRAMES       = 64;
    localparam int CFR_OWNER_ID_BITS    = 8;
    localparam int CFR_PAGE_NUMBER_BITS = 20;

    typedef enum logic [2:0] {
        REQ_ALLOC  = 3'd0,
        REQ_FREE   = 3'd1,
        REQ_ACCESS = 3'd2,
        REQ_PIN    = 3'd3,
        REQ_UNPIN  = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SLOT = 2'd1,
        ST_NO_FRAME = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FREE_SCAN,
        S_SWEEP,
        S_SLOT_RD,
        S_SLOT_CHK,
        S_PIN_PAGE,
        S_PIN_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  granted_slot;
        logic        evicted;
        logic [7:0]  victim_owner;
        logic [19:0] victim_page;
        logic        victim_to_swap;
    } t_result;

endpackage

// ===== sv/clock_frame_replacement_unit.sv =====
// ----------------------------------------------------------------------------
// clock_frame_replacement_unit
// Frame table with second-chance clock eviction behind a stream interface.
// ----------------------------------------------------------------------------
// One request is worked at a time; each gives one result item. The frame
// table is reached through a single read port. Free and access read the
// slot and then check it; allocate scans for a free slot and, if none is
// found, sweeps the hand up to two times round for a victim; pin and unpin
// scan the table once per covered page (up to 17 pages). After reset a
// clearing pass over every frame runs before the first item is taken. A
// finished result sits in the output register while the next item is
// accepted.
`timescale 1ns / 1ps

`include "clock_frame_replacement_unit_macros.svh"

module clock_frame_replacement_unit
    import cfr_pkg::*;
#(
    parameter int NUM_FRAMES       = CFR_NUM_FRAMES,
    parameter int OWNER_ID_BITS    = CFR_OWNER_ID_BITS,
    parameter int PAGE_NUMBER_BITS = CFR_PAGE_NUMBER_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // owner_id[7:0], virtual_address[39:8], length_bytes[55:40],
    // frame_slot[61:56], is_write[62], reloadable[63]
    input  logic [63:0] s_axis_tdata,
    // req_type[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // granted_slot[5:0], evicted[6], victim_owner[14:7], victim_page[34:15],
    // victim_to_swap[35], zero fill[39:36]
    output logic [39:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]  m_axis_tuser
);

    logic    out_free, push;
    t_result res;

    assign out_free = !m_axis_tvalid || m_axis_tready;

    cfr_ctrl #(
        .NUM_FRAMES       (NUM_FRAMES),
        .OWNER_ID_BITS    (OWNER_ID_BITS),
        .PAGE_NUMBER_BITS (PAGE_NUMBER_BITS)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (s_axis_tvalid),
        .o_ready           (s_axis_tready),
        .i_req_type        (s_axis_tuser),
        .i_owner_id        (s_axis_tdata[7:0]),
        .i_virtual_address (s_axis_tdata[39:8]),
        .i_length_bytes    (s_axis_tdata[55:40]),
        .i_frame_slot      (s_axis_tdata[61:56]),
        .i_is_write        (s_axis_tdata[62]),
        .i_reloadable      (s_axis_tdata[63]),
        .i_out_free        (out_free),
        .o_push            (push),
        .o_result          (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (push) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            m_axis_tuser <= res.status;
            m_axis_tdata <= {4'b0000, res.victim_to_swap, res.victim_page,
                             res.victim_owner, res.evicted, res.granted_slot};
        end
    end

    `CFR_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `CFR_ASSERT_IMPL(a_status_code, m_axis_tvalid, m_axis_tuser != 2'd3)
    `CFR_ASSERT_IMPL(a_evict_ok, m_axis_tvalid && m_axis_tdata[6], m_axis_tuser == ST_OK)
    `CFR_ASSERT_IMPL(a_no_frame_clean, m_axis_tvalid && m_axis_tuser == ST_NO_FRAME,
                     m_axis_tdata[35:0] == 36'd0)

endmodule

// ===== sv/cfr_frame_mem.sv =====
// ----------------------------------------------------------------------------
// cfr_frame_mem
// Frame table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfr_frame_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 33
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ===== sv/cfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfr_ctrl
// Request sequencer: scans, sweeps and read-modify-writes the frame table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfr_ctrl
    import cfr_pkg::*;
#(
    parameter int NUM_FRAMES       = CFR_NUM_FRAMES,
    parameter int OWNER_ID_BITS    = CFR_OWNER_ID_BITS,
    parameter int PAGE_NUMBER_BITS = CFR_PAGE_NUMBER_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [2:0]    i_req_type,
    input  logic [7:0]    i_owner_id,
    input  logic [31:0]   i_virtual_address,
    input  logic [15:0]   i_length_bytes,
    input  logic [5:0]    i_frame_slot,
    input  logic          i_is_write,
    input  logic          i_reloadable,
    input  logic          i_out_free,
    output logic          o_push,
    output t_result       o_result
);

    localparam int SW   = $clog2(NUM_FRAMES);
    localparam int OB   = OWNER_ID_BITS;
    localparam int PB   = PAGE_NUMBER_BITS;
    localparam int EW   = 5 + OB + PB;
    localparam int CW   = $clog2(2 * NUM_FRAMES) + 1;
    localparam int B_VAL = 0;
    localparam int B_PIN = 1;
    localparam int B_ACC = 2;
    localparam int B_DRT = 3;
    localparam int B_REL = 4;
    localparam int B_OWN = 5;
    localparam int B_PG  = 5 + OB;
    localparam logic [SW-1:0] LAST      = SW'(NUM_FRAMES - 1);
    localparam logic [CW-1:0] SWEEP_END = CW'(2 * NUM_FRAMES - 1);

    function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
        return (s == LAST) ? '0 : s + 1'b1;
    endfunction

    t_state          r_state, n_state;
    logic [SW-1:0]   r_idx, r_prev, r_hand;
    logic            r_pv;
    logic [CW-1:0]   r_cnt;
    logic [2:0]      r_req;
    logic [OB-1:0]   r_own;
    logic [PB-1:0]   r_fill_page;
    logic            r_rel;
    logic            r_wr;
    logic [20:0]     r_page;
    logic [32:0]     r_end;
    t_result         r_res;

    logic            mem_wr_en;
    logic [SW-1:0]   mem_wr_addr;
    logic [EW-1:0]   mem_wr_data;
    logic [EW-1:0]   mem_rd_data;

    cfr_frame_mem #(
        .DEPTH (NUM_FRAMES),
        .WIDTH (EW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (r_idx),
        .o_rd_data (mem_rd_data)
    );

    logic          e_val, e_pin, e_acc, e_drt, e_rel;
    logic [OB-1:0] e_own;
    logic [PB-1:0] e_page;
    logic [EW-1:0] fill_data;
    logic [PB-1:0] pin_key;
    logic          accept, slot_bad, slot_req;
    logic [1:0]    acc_status;
    logic          free_hit, free_last, sw_acc, sw_vic, sw_end;
    logic          pin_in, pin_hit, pin_last;

    assign e_val  = mem_rd_data[B_VAL];
    assign e_pin  = mem_rd_data[B_PIN];
    assign e_acc  = mem_rd_data[B_ACC];
    assign e_drt  = mem_rd_data[B_DRT];
    assign e_rel  = mem_rd_data[B_REL];
    assign e_own  = mem_rd_data[B_OWN +: OB];
    assign e_page = mem_rd_data[B_PG +: PB];

    assign fill_data = {r_fill_page, r_own, r_rel, 3'b000, 1'b1};
    assign pin_key   = PB'(r_page[19:0]);

    assign accept    = i_valid && o_ready;
    assign slot_bad  = 32'(i_frame_slot) >= NUM_FRAMES;
    assign slot_req  = (i_req_type == REQ_FREE) || (i_req_type == REQ_ACCESS);
    assign acc_status = ((slot_req && slot_bad) || (i_req_type > REQ_UNPIN)) ?
                        ST_BAD_SLOT : ST_OK;

    assign free_hit  = r_pv && !e_val;
    assign free_last = r_pv && e_val && (r_prev == LAST);
    assign sw_acc    = r_pv && e_acc;
    assign sw_vic    = r_pv && !e_acc && !e_pin;
    assign sw_end    = r_pv && !sw_vic && (r_cnt == SWEEP_END);
    // page start must lie below the range end and inside the 32-bit space
    assign pin_in    = ({r_page, 12'b0} < r_end) && !r_page[20];
    assign pin_hit   = r_pv && e_val && (e_own == r_own) && (e_page == pin_key);
    assign pin_last  = r_pv && !pin_hit && (r_prev == LAST);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:     if (r_idx == LAST) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        REQ_ALLOC:              n_state = S_FREE_SCAN;
                        REQ_FREE, REQ_ACCESS:   n_state = slot_bad ? S_DONE : S_SLOT_RD;
                        REQ_PIN, REQ_UNPIN:     n_state = S_PIN_PAGE;
                        default:                n_state = S_DONE;
                    endcase
                end
            end
            S_FREE_SCAN: begin
                if (free_hit)       n_state = S_DONE;
                else if (free_last) n_state = S_SWEEP;
            end
            S_SWEEP:     if (sw_vic || sw_end) n_state = S_DONE;
            S_SLOT_RD:   n_state = S_SLOT_CHK;
            S_SLOT_CHK:  n_state = S_DONE;
            S_PIN_PAGE:  n_state = pin_in ? S_PIN_SCAN : S_DONE;
            S_PIN_SCAN:  if (pin_hit || pin_last) n_state = S_PIN_PAGE;
            S_DONE:      if (i_out_free) n_state = S_IDLE;
            default:     n_state = S_CLEAR;
        endcase
    end

    // outputs and memory write port
    always_comb begin
        o_ready     = (r_state == S_IDLE);
        o_push      = (r_state == S_DONE) && i_out_free;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_prev;
        mem_wr_data = mem_rd_data;
        unique case (r_state)
            S_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_idx;
                mem_wr_data = '0;
            end
            S_FREE_SCAN: begin
                mem_wr_en   = free_hit;
                mem_wr_data = fill_data;
            end
            S_SWEEP: begin
                mem_wr_en = sw_acc || sw_vic;
                if (sw_vic) begin
                    mem_wr_data = fill_data;
                end else begin
                    mem_wr_data[B_ACC] = 1'b0;
                end
            end
            S_SLOT_CHK: begin
                mem_wr_en   = e_val;
                mem_wr_addr = r_idx;
                if (r_req == REQ_FREE) begin
                    mem_wr_data[B_VAL] = 1'b0;
                    mem_wr_data[B_PIN] = 1'b0;
                    mem_wr_data[B_ACC] = 1'b0;
                    mem_wr_data[B_DRT] = 1'b0;
                end else begin
                    mem_wr_data[B_ACC] = 1'b1;
                    mem_wr_data[B_DRT] = e_drt | r_wr;
                end
            end
            S_PIN_SCAN: begin
                mem_wr_en          = pin_hit;
                mem_wr_data[B_PIN] = (r_req == REQ_PIN);
            end
            default: begin
                mem_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_hand  <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_prev  <= r_idx;
            // read data is meaningful in the cycle after an address inside a scan
            r_pv    <= (n_state == r_state) &&
                       (r_state == S_FREE_SCAN || r_state == S_SWEEP ||
                        r_state == S_PIN_SCAN);
            case (r_state)
                S_CLEAR: r_idx <= next_slot(r_idx);
                S_IDLE: begin
                    if (accept) begin
                        r_req       <= i_req_type;
                        r_own       <= OB'(i_owner_id);
                        r_fill_page <= PB'(i_virtual_address[31:12]);
                        r_rel       <= i_reloadable;
                        r_wr        <= i_is_write;
                        r_page      <= {1'b0, i_virtual_address[31:12]};
                        r_end       <= 33'(i_virtual_address) + 33'(i_length_bytes);
                        r_res       <= {acc_status, 36'd0};
                        r_idx       <= (slot_req && !slot_bad) ? SW'(i_frame_slot) : '0;
                    end
                end
                S_FREE_SCAN: begin
                    r_idx <= free_last ? r_hand : next_slot(r_idx);
                    if (free_hit) begin
                        r_res.granted_slot <= 6'(r_prev);
                    end else if (free_last) begin
                        r_cnt <= '0;
                    end
                end
                S_SWEEP: begin
                    r_idx <= next_slot(r_idx);
                    if (r_pv) r_cnt <= r_cnt + 1'b1;
                    if (sw_vic) begin
                        r_res.granted_slot   <= 6'(r_prev);
                        r_res.evicted        <= 1'b1;
                        r_res.victim_owner   <= 8'(e_own);
                        r_res.victim_page    <= 20'(e_page);
                        r_res.victim_to_swap <= e_drt | ~e_rel;
                        r_hand               <= next_slot(r_prev);
                    end else if (sw_end) begin
                        r_res.status <= ST_NO_FRAME;
                    end
                end
                S_SLOT_CHK: begin
                    if (!e_val) begin
                        r_res.status <= ST_BAD_SLOT;
                    end else if (r_req == REQ_FREE && r_hand == r_idx) begin
                        r_hand <= next_slot(r_idx);
                    end
                end
                S_PIN_PAGE: r_idx <= '0;
                S_PIN_SCAN: begin
                    r_idx <= next_slot(r_idx);
                    if (pin_hit || pin_last) r_page <= r_page + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_result = r_res;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench of the clock frame replacement unit: random and directed
// requests, a scoreboard that mirrors the frame table and hand, random idling
// on both sides and one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import cfr_pkg::*;

    localparam int NF = CFR_NUM_FRAMES;
    localparam int CYCLE_LIMIT = 10000000;

    typedef struct packed {
        logic [2:0]  req;
        logic [7:0]  owner;
        logic [31:0] va;
        logic [15:0] len;
        logic [5:0]  slot;
        logic        wr;
        logic        rel;
    } t_request;

    class frame_scoreboard;
        bit          valid [NF];
        logic [7:0]  owner [NF];
        logic [19:0] page [NF];
        bit          pinned [NF];
        bit          accessed [NF];
        bit          dirty [NF];
        bit          rel [NF];
        int          hand;
        t_result     pending [$];
        int          errors;
        int          evictions;
        int          no_frames;

        function new();
            for (int i = 0; i < NF; i++) begin
                valid[i] = 0; pinned[i] = 0; accessed[i] = 0; dirty[i] = 0;
                owner[i] = 0; page[i] = 0; rel[i] = 0;
            end
            hand = 0; errors = 0; evictions = 0; no_frames = 0;
        endfunction

        function int next(int s);
            return (s + 1 >= NF) ? 0 : s + 1;
        endfunction

        function void fill(int s, logic [7:0] o, logic [19:0] p, bit r);
            valid[s] = 1; owner[s] = o; page[s] = p;
            pinned[s] = 0; accessed[s] = 0; dirty[s] = 0; rel[s] = r;
        endfunction

        function void mark_range(logic [7:0] o, logic [31:0] va, logic [15:0] len, bit m);
            logic [32:0] stop;
            logic [20:0] p;
            stop = {1'b0, va} + 33'(len);
            p = {1'b0, va[31:12]};
            while ({p, 12'h000} < stop && p <= 21'hFFFFF) begin
                for (int s = 0; s < NF; s++)
                    if (valid[s] && owner[s] == o && page[s] == p[19:0]) begin
                        pinned[s] = m;
                        break;
                    end
                p++;
            end
        endfunction

        function void note_request(t_request r);
            t_result res;
            int found, h, victim;
            res = '0;
            case (r.req)
                REQ_ALLOC: begin
                    found = -1;
                    for (int s = 0; s < NF; s++)
                        if (!valid[s]) begin found = s; break; end
                    if (found >= 0) begin
                        fill(found, r.owner, r.va[31:12], r.rel);
                        res.granted_slot = 6'(found);
                    end else begin
                        h = hand; victim = -1;
                        for (int k = 0; k < 2 * NF; k++) begin
                            if (accessed[h]) accessed[h] = 0;
                            else if (!pinned[h]) begin victim = h; break; end
                            h = next(h);
                        end
                        if (victim < 0) begin
                            res.status = ST_NO_FRAME;
                            hand = h;
                            no_frames++;
                        end else begin
                            res.evicted = 1;
                            res.victim_owner = owner[victim];
                            res.victim_page = page[victim];
                            res.victim_to_swap = dirty[victim] || !rel[victim];
                            fill(victim, r.owner, r.va[31:12], r.rel);
                            res.granted_slot = 6'(victim);
                            hand = next(victim);
                            evictions++;
                        end
                    end
                end
                REQ_FREE, REQ_ACCESS: begin
                    if (!valid[r.slot]) res.status = ST_BAD_SLOT;
                    else if (r.req == REQ_FREE) begin
                        valid[r.slot] = 0; pinned[r.slot] = 0;
                        accessed[r.slot] = 0; dirty[r.slot] = 0;
                        if (hand == r.slot) hand = next(r.slot);
                    end else begin
                        accessed[r.slot] = 1;
                        if (r.wr) dirty[r.slot] = 1;
                    end
                end
                REQ_PIN: mark_range(r.owner, r.va, r.len, 1);
                REQ_UNPIN: mark_range(r.owner, r.va, r.len, 0);
                default: res.status = ST_BAD_SLOT;
            endcase
            pending.push_back(res);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(logic [1:0] st, logic [39:0] d);
            t_result e;
            if (pending.size() == 0) begin
                report("unexpected item", d[31:0], 0);
                return;
            end
            e = pending.pop_front();
            if (st != e.status) report("status", 32'(st), 32'(e.status));
            if (d[5:0] != e.granted_slot)
                report("granted_slot", 32'(d[5:0]), 32'(e.granted_slot));
            if (d[6] != e.evicted) report("evicted", 32'(d[6]), 32'(e.evicted));
            if (d[14:7] != e.victim_owner)
                report("victim_owner", 32'(d[14:7]), 32'(e.victim_owner));
            if (d[34:15] != e.victim_page)
                report("victim_page", 32'(d[34:15]), 32'(e.victim_page));
            if (d[35] != e.victim_to_swap)
                report("victim_to_swap", 32'(d[35]), 32'(e.victim_to_swap));
            if (d[39:36] != 0) report("zero fill", 32'(d[39:36]), 0);
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    frame_scoreboard sb;
    int  cycles = 0;
    int  sent = 0;
    bit  calm = 0;      // last part of the run: no idling
    int  hold_off = 0;  // long receiver stall, in cycles

    clock_frame_replacement_unit dut (.*);

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: random stall bursts plus one long hold-off
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off > 0) begin
                m_axis_tready <= 0;
                repeat (hold_off) @(posedge i_clk);
                hold_off = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 17);
                m_axis_tready <= 0;
                repeat (gap) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata);

    task automatic send(t_request r);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= r.req;
        s_axis_tdata <= {r.rel, r.wr, r.slot, r.len, r.va, r.owner};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(r);
        sent++;
    endtask

    function automatic t_request make(logic [2:0] q, logic [7:0] o, logic [31:0] va,
                                      logic [15:0] len, logic [5:0] s, bit wr, bit rel);
        t_request r;
        r = '{q, o, va, len, s, wr, rel};
        return r;
    endfunction

    // mostly small owner/page pools so lookups and pins hit resident pages
    function automatic t_request random_request();
        t_request r;
        int k;
        r.owner = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        r.va = ($urandom_range(0, 9) == 0) ? $urandom
               : {12'h0, 8'($urandom_range(0, 15)), 12'($urandom)};
        r.len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 9000));
        r.slot = 6'($urandom);
        r.wr = 1'($urandom);
        r.rel = 1'($urandom);
        k = $urandom_range(0, 99);
        if (k < 35) r.req = REQ_ALLOC;
        else if (k < 50) r.req = REQ_FREE;
        else if (k < 75) r.req = REQ_ACCESS;
        else if (k < 85) r.req = REQ_PIN;
        else if (k < 96) r.req = REQ_UNPIN;
        else r.req = 3'($urandom_range(5, 7));
        return r;
    endfunction

    initial begin
        int waited;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: bad slots, unknown codes, field extremes
        send(make(REQ_FREE, 8'h00, 32'h0, 16'h0, 6'd0, 0, 0));
        send(make(REQ_ACCESS, 8'hFF, 32'hFFFFFFFF, 16'hFFFF, 6'd63, 1, 1));
        send(make(3'd5, 8'h00, 32'h0, 16'h0, 6'd0, 0, 0));
        send(make(3'd7, 8'hFF, 32'hFFFFFFFF, 16'hFFFF, 6'd63, 1, 1));
        send(make(REQ_ALLOC, 8'hFF, 32'hFFFFFFFF, 16'h0, 6'd0, 0, 1));
        send(make(REQ_ALLOC, 8'h00, 32'h00000000, 16'h0, 6'd63, 1, 0));
        // pin at the top of the address space, zero length unaligned
        send(make(REQ_PIN, 8'hFF, 32'hFFFFF800, 16'hFFFF, 6'd0, 0, 0));
        send(make(REQ_PIN, 8'h00, 32'h00000123, 16'h0, 6'd0, 0, 0));
        send(make(REQ_UNPIN, 8'h00, 32'h00000000, 16'h0, 6'd0, 0, 0));
        send(make(REQ_ACCESS, 8'h00, 32'h0, 16'h0, 6'd1, 1, 0));
        send(make(REQ_FREE, 8'h00, 32'h0, 16'h0, 6'd0, 0, 0));
        // fill the table, pin every page, then ask for one more: no frame
        for (int i = 0; i < NF; i++)
            if (!sb.valid[i]) send(make(REQ_ALLOC, 8'h07, {12'h0, 8'(i), 12'h0},
                                        16'h0, 6'd0, 0, 1));
        send(make(REQ_PIN, 8'hFF, 32'hFFFFF000, 16'h0, 6'd0, 0, 0));
        send(make(REQ_PIN, 8'h00, 32'h0, 16'h1000, 6'd0, 0, 0));
        send(make(REQ_PIN, 8'h07, 32'h0, 16'hFFFF, 6'd0, 0, 0));
        send(make(REQ_PIN, 8'h07, 32'h00010000, 16'hFFFF, 6'd0, 0, 0));
        send(make(REQ_PIN, 8'h07, 32'h00020000, 16'hFFFF, 6'd0, 0, 0));
        send(make(REQ_PIN, 8'h07, 32'h00030000, 16'hFFFF, 6'd0, 0, 0));
        send(make(REQ_ACCESS, 8'h0, 32'h0, 16'h0, 6'd5, 0, 0));
        send(make(REQ_ALLOC, 8'h09, 32'h12345000, 16'h0, 6'd0, 0, 0));
        // free the hand's slot, unpin owner 7's low pages, then refill it and evict
        send(make(REQ_FREE, 8'h0, 32'h0, 16'h0, 6'(sb.hand), 0, 0));
        send(make(REQ_UNPIN, 8'h07, 32'h0, 16'hFFFF, 6'd0, 0, 0));
        send(make(REQ_ALLOC, 8'h01, 32'h00005000, 16'h0, 6'd0, 0, 1));
        send(make(REQ_ALLOC, 8'h01, 32'h00006000, 16'h0, 6'd0, 1, 0));

        // random part; one long output hold-off partway through
        for (int n = 0; n < 2000; n++) begin
            if (n == 700) hold_off = 3000;
            if (n == 1800) calm = 1;
            send(random_request());
        end
        s_axis_tvalid <= 0;

        waited = 0;
        while (sb.pending.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (3 * NF + 10) @(posedge i_clk);
        if (sb.pending.size() != 0)
            sb.report("missing items", sb.pending.size(), 0);

        $display("%0d requests sent, %0d evictions, %0d no-frame results",
                 sent, sb.evictions, sb.no_frames);
        if (sb.errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
